### design/tcw_pkg.sv
// Shared types and constants for the text console character writer.
`timescale 1ns / 1ps

package tcw_pkg;

   // Default screen geometry and tab spacing.
   localparam int DEFAULT_SCREEN_WIDTH  = 80;
   localparam int DEFAULT_SCREEN_HEIGHT = 25;
   localparam int DEFAULT_TAB_STOP      = 8;

   // Fixed widths of the transfer fields.
   localparam int OPERATION_W     = 2;
   localparam int CHAR_W          = 8;
   localparam int COLUMN_IN_W     = 7;
   localparam int ROW_IN_W        = 5;
   localparam int CURSOR_OFFSET_W = 11;
   localparam int CURSOR_COLUMN_W = 7;
   localparam int CURSOR_ROW_W    = 5;
   localparam int ATTR_W          = 8;
   localparam int CELL_W          = CHAR_W + ATTR_W;

   // Character codes with special meaning, and the reset attribute.
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'd7;

   // Operation codes of a request.
   typedef enum logic [OPERATION_W-1:0] {
      OP_PRINT = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Request payload.
   typedef struct packed {
      logic [OPERATION_W-1:0] operation;
      logic [CHAR_W-1:0]      char_code;
      logic [COLUMN_IN_W-1:0] column;
      logic [ROW_IN_W-1:0]    row;
   } req_type;

   // Response payload.
   typedef struct packed {
      logic [CURSOR_OFFSET_W-1:0] cursor_offset;
      logic [CURSOR_COLUMN_W-1:0] cursor_column;
      logic [CURSOR_ROW_W-1:0]    cursor_row;
      logic [CHAR_W-1:0]          cell_char;
      logic [ATTR_W-1:0]          cell_attr;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;
      logic fill_step;
      logic fill_reset_attr;
      logic scroll_step;
      logic print_write;
      logic newline;
      logic mod_init;
      logic mod_step;
      logic tab_add;
      logic norm_step;
      logic set_cursor;
      logic read_cell;
      logic load_result;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      op_type op;
      logic   is_newline;
      logic   is_tab;
      logic   fill_last;
      logic   scroll_last;
      logic   col_over;
      logic   row_over;
      logic   result_free;
   } status_type;

endpackage

### design/tcw_ctrl.sv
// Controller state machine that sequences every request through the datapath.
`timescale 1ns / 1ps

module tcw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  tcw_pkg::status_type status,
   output tcw_pkg::cmd_type    cmd
);
   import tcw_pkg::*;

   typedef enum logic [13:0] {
      ST_INIT     = 14'b00000000000001,
      ST_IDLE     = 14'b00000000000010,
      ST_DECODE   = 14'b00000000000100,
      ST_PRINT    = 14'b00000000001000,
      ST_NEWLINE  = 14'b00000000010000,
      ST_TAB_MOD  = 14'b00000000100000,
      ST_TAB_ADD  = 14'b00000001000000,
      ST_TAB_NORM = 14'b00000010000000,
      ST_CHECK    = 14'b00000100000000,
      ST_SCROLL   = 14'b00001000000000,
      ST_CLEAR    = 14'b00010000000000,
      ST_READ     = 14'b00100000000000,
      ST_SETPOS   = 14'b01000000000000,
      ST_DONE     = 14'b10000000000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // State register; reset starts the clearing pass over the cell store.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and command decode.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_INIT: begin
            cmd.fill_step       = 1'b1;
            cmd.fill_reset_attr = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (status.op)
               OP_PRINT: begin
                  if (status.is_newline) begin
                     state_in = ST_NEWLINE;
                  end else if (status.is_tab) begin
                     cmd.mod_init = 1'b1;
                     state_in     = ST_TAB_MOD;
                  end else begin
                     state_in = ST_PRINT;
                  end
               end
               OP_SET:   state_in = ST_SETPOS;
               OP_CLEAR: state_in = ST_CLEAR;
               OP_READ:  state_in = ST_READ;
               default:  state_in = ST_DONE;
            endcase
         end
         ST_PRINT: begin
            cmd.print_write = 1'b1;
            state_in        = ST_CHECK;
         end
         ST_NEWLINE: begin
            cmd.newline = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_TAB_MOD: begin
            cmd.mod_step = 1'b1;
            state_in     = ST_TAB_ADD;
         end
         ST_TAB_ADD: begin
            cmd.tab_add = 1'b1;
            state_in    = ST_TAB_NORM;
         end
         ST_TAB_NORM: begin
            cmd.norm_step = 1'b1;
            if (!status.col_over) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.row_over ? ST_SCROLL : ST_DONE;
         end
         ST_SCROLL: begin
            cmd.scroll_step = 1'b1;
            if (status.scroll_last) begin
               state_in = ST_DONE;
            end
         end
         ST_CLEAR: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_DONE;
            end
         end
         ST_READ: begin
            cmd.read_cell = 1'b1;
            state_in      = ST_DONE;
         end
         ST_SETPOS: begin
            cmd.set_cursor = 1'b1;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            // Wait here only while the previous response is still unclaimed.
            if (status.result_free) begin
               cmd.load_result = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### design/tcw_datapath.sv
// Datapath: cursor registers, tab remainder unit, sweep counter, cell store and response register.
`timescale 1ns / 1ps

module tcw_datapath #(
   parameter int SCREEN_WIDTH  = tcw_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcw_pkg::DEFAULT_SCREEN_HEIGHT,
   parameter int TAB_STOP      = tcw_pkg::DEFAULT_TAB_STOP
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcw_pkg::req_type         req_data,
   output tcw_pkg::rsp_type         rsp_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  logic                     csr_write_enable,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_write_data,
   input  tcw_pkg::cmd_type         cmd,
   output tcw_pkg::status_type      status
);
   import tcw_pkg::*;

   localparam int CELL_COUNT  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W      = $clog2(CELL_COUNT);
   localparam int OFFSET_W    = $clog2(CELL_COUNT + TAB_STOP);
   localparam int COL_W       = $clog2(SCREEN_WIDTH + TAB_STOP);
   localparam int ROW_W       = $clog2(SCREEN_HEIGHT + 2);
   localparam int TAB_W       = $clog2(TAB_STOP + 1);
   localparam int RECIP_SHIFT = OFFSET_W + TAB_W;
   localparam int PROD_W      = OFFSET_W + RECIP_SHIFT;
   localparam logic [RECIP_SHIFT-1:0] RECIP =
      RECIP_SHIFT'((2 ** RECIP_SHIFT + TAB_STOP - 1) / TAB_STOP);
   localparam int SWEEP_W     = $clog2(CELL_COUNT + 1);
   localparam int SCAN_W      = SWEEP_W + 1;
   localparam int SCROLL_BASE = (SCREEN_HEIGHT - 1) * SCREEN_WIDTH;

   // Configuration and latched request.
   logic [ATTR_W-1:0]   attr_ff;
   op_type              op_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [COL_W-1:0]    item_col_ff;
   logic [ROW_W-1:0]    item_row_ff;
   logic [OFFSET_W-1:0] item_offset_ff;
   logic [COL_W-1:0]    clamp_col;
   logic [ROW_W-1:0]    clamp_row;

   // Cursor.
   logic [COL_W-1:0]    col_ff,    col_in;
   logic [ROW_W-1:0]    row_ff,    row_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;

   // Tab remainder unit.
   logic [PROD_W-1:0]   recip_prod;
   logic [OFFSET_W-1:0] quot_ff, quot_in;
   logic [OFFSET_W-1:0] rem_full;
   logic [TAB_W-1:0]    rem_ff,  rem_in;
   logic [TAB_W-1:0]    tab_inc;

   // Sweep counter for clearing and scrolling.
   logic [SWEEP_W-1:0]  sweep_ff, sweep_in;
   logic [SCAN_W-1:0]   scroll_src;
   logic                fill_last;
   logic                scroll_last;

   // Cell store.
   logic [CELL_W-1:0]   cells [CELL_COUNT];
   logic [CELL_W-1:0]   rdata_ff;
   logic [CELL_W-1:0]   blank;
   logic                mem_we, mem_re;
   logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
   logic [CELL_W-1:0]   mem_wdata;

   // Response register.
   rsp_type             rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // Attribute register written by the configuration port.
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
      end else if (csr_write_enable) begin
         attr_ff <= csr_write_data;
      end
   end

   // Coordinates saturate at the screen edge; the offset is formed at request time.
   always_comb begin
      clamp_col = (32'(req_data.column) > 32'(SCREEN_WIDTH - 1)) ?
                  COL_W'(SCREEN_WIDTH - 1) : COL_W'(req_data.column);
      clamp_row = (32'(req_data.row) > 32'(SCREEN_HEIGHT - 1)) ?
                  ROW_W'(SCREEN_HEIGHT - 1) : ROW_W'(req_data.row);
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         op_ff          <= op_type'(req_data.operation);
         char_ff        <= req_data.char_code;
         item_col_ff    <= clamp_col;
         item_row_ff    <= clamp_row;
         item_offset_ff <= OFFSET_W'(clamp_row) * OFFSET_W'(SCREEN_WIDTH) +
                           OFFSET_W'(clamp_col);
      end
   end

   // Tab remainder: a reciprocal multiply gives the quotient by the tab stop,
   // and the next cycle subtracts quotient times tab stop from the offset.
   assign recip_prod = PROD_W'(offset_ff) * PROD_W'(RECIP);
   assign rem_full   = offset_ff - quot_ff * OFFSET_W'(TAB_STOP);
   assign tab_inc    = TAB_W'(TAB_STOP) - rem_ff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      if (cmd.mod_init) begin
         quot_in = recip_prod[PROD_W-1:RECIP_SHIFT];
      end
      if (cmd.mod_step) begin
         rem_in = rem_full[TAB_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
   end

   // Sweep counter returns to zero at the end of every pass.
   assign fill_last   = (sweep_ff == SWEEP_W'(CELL_COUNT - 1));
   assign scroll_last = (sweep_ff == SWEEP_W'(CELL_COUNT));
   assign scroll_src  = SCAN_W'(sweep_ff) + SCAN_W'(SCREEN_WIDTH);

   always_comb begin
      sweep_in = sweep_ff;
      if (cmd.fill_step) begin
         sweep_in = fill_last ? '0 : sweep_ff + SWEEP_W'(1);
      end else if (cmd.scroll_step) begin
         sweep_in = scroll_last ? '0 : sweep_ff + SWEEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sweep_ff <= '0;
      end else begin
         sweep_ff <= sweep_in;
      end
   end

   // Cursor updates for each kind of movement.
   always_comb begin
      col_in    = col_ff;
      row_in    = row_ff;
      offset_in = offset_ff;
      if (cmd.set_cursor) begin
         col_in    = item_col_ff;
         row_in    = item_row_ff;
         offset_in = item_offset_ff;
      end else if (cmd.print_write) begin
         offset_in = offset_ff + OFFSET_W'(1);
         if (col_ff == COL_W'(SCREEN_WIDTH - 1)) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end else if (cmd.newline) begin
         offset_in = offset_ff + OFFSET_W'(SCREEN_WIDTH) - OFFSET_W'(col_ff);
         col_in    = '0;
         row_in    = row_ff + ROW_W'(1);
      end else if (cmd.tab_add) begin
         col_in    = col_ff + COL_W'(tab_inc);
         offset_in = offset_ff + OFFSET_W'(tab_inc);
      end else if (cmd.norm_step && status.col_over) begin
         col_in = col_ff - COL_W'(SCREEN_WIDTH);
         row_in = row_ff + ROW_W'(1);
      end else if (cmd.scroll_step && scroll_last) begin
         col_in    = '0;
         row_in    = ROW_W'(SCREEN_HEIGHT - 1);
         offset_in = OFFSET_W'(SCROLL_BASE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         offset_ff <= '0;
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         offset_ff <= offset_in;
      end
   end

   // Store port selection. A scroll reads one row ahead and writes the cell behind it.
   assign blank = {(cmd.fill_reset_attr ? ATTR_RESET : attr_ff), CHAR_SPACE};

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = offset_ff[ADDR_W-1:0];
      mem_wdata = {attr_ff, char_ff};
      if (cmd.print_write) begin
         mem_we = 1'b1;
      end else if (cmd.fill_step) begin
         mem_we    = 1'b1;
         mem_waddr = sweep_ff[ADDR_W-1:0];
         mem_wdata = blank;
      end else if (cmd.scroll_step && (sweep_ff != '0)) begin
         mem_we    = 1'b1;
         mem_waddr = ADDR_W'(sweep_ff - SWEEP_W'(1));
         mem_wdata = (sweep_ff <= SWEEP_W'(SCROLL_BASE)) ? rdata_ff : blank;
      end
   end

   always_comb begin
      mem_re    = 1'b0;
      mem_raddr = item_offset_ff[ADDR_W-1:0];
      if (cmd.read_cell) begin
         mem_re = 1'b1;
      end else if (cmd.scroll_step && (scroll_src < SCAN_W'(CELL_COUNT))) begin
         mem_re    = 1'b1;
         mem_raddr = scroll_src[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         cells[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= cells[mem_raddr];
      end
   end

   // Response register holds a result until its transfer completes.
   always_comb begin
      rsp_in                = rsp_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      if (cmd.load_result) begin
         rsp_in.cursor_offset = CURSOR_OFFSET_W'(offset_ff);
         rsp_in.cursor_column = CURSOR_COLUMN_W'(col_ff);
         rsp_in.cursor_row    = CURSOR_ROW_W'(row_ff);
         rsp_in.cell_char     = (op_ff == OP_READ) ? rdata_ff[CHAR_W-1:0] : '0;
         rsp_in.cell_attr     = (op_ff == OP_READ) ? rdata_ff[CELL_W-1:CHAR_W] : '0;
         rsp_valid_in         = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

   // Status back to the controller.
   always_comb begin
      status             = '0;
      status.op          = op_ff;
      status.is_newline  = (char_ff == CHAR_NEWLINE);
      status.is_tab      = (char_ff == CHAR_TAB);
      status.fill_last   = fill_last;
      status.scroll_last = scroll_last;
      status.col_over    = (32'(col_ff) >= 32'(SCREEN_WIDTH));
      status.row_over    = (32'(row_ff) >= 32'(SCREEN_HEIGHT));
      status.result_free = !rsp_valid_ff || rsp_ready;
   end

endmodule

### design/text_console_char_writer.sv
// Top level of the text console character writer: controller plus datapath.
//
// Requests arrive on the req_ channel (valid/ready) and each one produces
// exactly one response transfer on the rsp_ channel: the cursor after the
// request, and the cell contents for a read. csr_write_enable writes the
// attribute byte used for printed, cleared and scrolled-in cells.
// Requests are handled one at a time by the controller state machine. A
// print or newline passes through decode, its write or cursor step and a
// row check. A tab takes a remainder step, an add and a normalising step in
// place of the write, the last again when the tab ends a row (the remainder
// by the tab stop comes from a reciprocal multiply). A clear walks the cell
// store once, one cell per cycle. A scroll, caused when the cursor runs past
// the last cell, adds one more pass of cells through the store's single write
// port. req_ready rises again in the cycle after the response is loaded.
// After reset the block clears the store to spaces with attribute 7, one
// cell per cycle with req_ready low; attribute writes are taken during that
// pass. A stalled receiver holds the response register; the next request is
// still taken and waits only to load its own response.
`timescale 1ns / 1ps

module text_console_char_writer #(
   parameter int SCREEN_WIDTH  = tcw_pkg::DEFAULT_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = tcw_pkg::DEFAULT_SCREEN_HEIGHT,
   parameter int TAB_STOP      = tcw_pkg::DEFAULT_TAB_STOP
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  tcw_pkg::req_type           req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output tcw_pkg::rsp_type           rsp_data,
   input  logic                       csr_write_enable,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_write_data
);
   import tcw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing of each request.
   tcw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Cursor, cell store and response register.
   tcw_datapath #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT),
      .TAB_STOP      (TAB_STOP)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_data         (req_data),
      .rsp_data         (rsp_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

### test/text_console_char_writer_tb.sv
// Self-checking testbench for the text console character writer.
`timescale 1ns / 1ps

module text_console_char_writer_tb;
   import tcw_pkg::*;

   // Screen geometry as built into the block under test.
   localparam int SCREEN_W    = DEFAULT_SCREEN_WIDTH;
   localparam int SCREEN_H    = DEFAULT_SCREEN_HEIGHT;
   localparam int TAB_W       = DEFAULT_TAB_STOP;
   localparam int CELL_COUNT  = SCREEN_W * SCREEN_H;
   localparam int LAST_ROW_AT = CELL_COUNT - SCREEN_W;

   // Run shape and limits.
   localparam int PHASE_COUNT      = 5;
   localparam int ITEMS_PER_PHASE  = 190;
   localparam int SETTLE_CYCLES    = 24;
   localparam int HOLDOFF_CYCLES   = 400;
   localparam int MAX_REPORTS      = 10;
   localparam longint CYCLE_LIMIT  = 8_000_000;

   // One directed row: a request and, where pinned, its expected response.
   typedef struct packed {
      req_type item;
      logic    pinned;
      rsp_type result;
   } directed_row_type;

   localparam int DIRECTED_COUNT = 25;
   localparam directed_row_type DIRECTED_ROWS [0:DIRECTED_COUNT-1] = '{
      // Reads right after reset see blank cells, including saturated coordinates.
      '{'{OP_READ,  8'h00, 7'd0,   5'd0},  1'b1, '{11'd0,    7'd0,  5'd0,  8'h20, 8'h07}},
      '{'{OP_READ,  8'hFF, 7'd127, 5'd31}, 1'b1, '{11'd0,    7'd0,  5'd0,  8'h20, 8'h07}},
      // Cursor to the last cell, then a print there scrolls the screen.
      '{'{OP_SET,   8'h00, 7'd127, 5'd31}, 1'b1, '{11'd1999, 7'd79, 5'd24, 8'h00, 8'h00}},
      '{'{OP_PRINT, 8'h41, 7'd0,   5'd0},  1'b1, '{11'd1920, 7'd0,  5'd24, 8'h00, 8'h00}},
      '{'{OP_READ,  8'h00, 7'd79,  5'd23}, 1'b1, '{11'd1920, 7'd0,  5'd24, 8'h41, 8'h07}},
      '{'{OP_READ,  8'h00, 7'd79,  5'd24}, 1'b1, '{11'd1920, 7'd0,  5'd24, 8'h20, 8'h07}},
      // Character extremes, then a tab and a newline that runs off the screen.
      '{'{OP_PRINT, 8'hFF, 7'd127, 5'd31}, 1'b1, '{11'd1921, 7'd1,  5'd24, 8'h00, 8'h00}},
      '{'{OP_PRINT, 8'h00, 7'd0,   5'd0},  1'b1, '{11'd1922, 7'd2,  5'd24, 8'h00, 8'h00}},
      '{'{OP_PRINT, CHAR_TAB, 7'd0, 5'd0}, 1'b1, '{11'd1928, 7'd8,  5'd24, 8'h00, 8'h00}},
      '{'{OP_PRINT, CHAR_NEWLINE, 7'd0, 5'd0},
                                           1'b1, '{11'd1920, 7'd0,  5'd24, 8'h00, 8'h00}},
      '{'{OP_READ,  8'h00, 7'd0,   5'd23}, 1'b1, '{11'd1920, 7'd0,  5'd24, 8'hFF, 8'h07}},
      '{'{OP_READ,  8'h00, 7'd1,   5'd23}, 1'b1, '{11'd1920, 7'd0,  5'd24, 8'h00, 8'h07}},
      // A tab from near the end of the screen also scrolls.
      '{'{OP_SET,   8'h00, 7'd77,  5'd24}, 1'b1, '{11'd1997, 7'd77, 5'd24, 8'h00, 8'h00}},
      '{'{OP_PRINT, CHAR_TAB, 7'd0, 5'd0}, 1'b1, '{11'd1920, 7'd0,  5'd24, 8'h00, 8'h00}},
      // Home, newline and tab from the top of the screen.
      '{'{OP_SET,   8'h00, 7'd0,   5'd0},  1'b1, '{11'd0,    7'd0,  5'd0,  8'h00, 8'h00}},
      '{'{OP_PRINT, CHAR_NEWLINE, 7'd0, 5'd0},
                                           1'b1, '{11'd80,   7'd0,  5'd1,  8'h00, 8'h00}},
      '{'{OP_PRINT, CHAR_TAB, 7'd0, 5'd0}, 1'b1, '{11'd88,   7'd8,  5'd1,  8'h00, 8'h00}},
      // Fields that do not belong to the operation must be ignored.
      '{'{OP_SET,   8'hFF, 7'd5,   5'd2},  1'b1, '{11'd165,  7'd5,  5'd2,  8'h00, 8'h00}},
      '{'{OP_PRINT, 8'h5A, 7'd127, 5'd31}, 1'b1, '{11'd166,  7'd6,  5'd2,  8'h00, 8'h00}},
      '{'{OP_READ,  8'hFF, 7'd5,   5'd2},  1'b1, '{11'd166,  7'd6,  5'd2,  8'h5A, 8'h07}},
      // Clear keeps the cursor and blanks every cell.
      '{'{OP_CLEAR, 8'hFF, 7'd127, 5'd31}, 1'b1, '{11'd166,  7'd6,  5'd2,  8'h00, 8'h00}},
      '{'{OP_READ,  8'h00, 7'd5,   5'd2},  1'b1, '{11'd166,  7'd6,  5'd2,  8'h20, 8'h07}},
      // Coordinates just past the screen saturate.
      '{'{OP_SET,   8'h00, 7'd80,  5'd25}, 1'b1, '{11'd1999, 7'd79, 5'd24, 8'h00, 8'h00}},
      '{'{OP_READ,  8'h00, 7'd127, 5'd0},  1'b1, '{11'd1999, 7'd79, 5'd24, 8'h20, 8'h07}},
      '{'{OP_PRINT, 8'h7F, 7'd0,   5'd0},  1'b0, '0}
   };

   // Clock, reset and block ports.
   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_write_enable = 1'b0;
   logic [ATTR_W-1:0]   csr_write_data = '0;

   // Shadow copy of the console state.
   logic [CELL_W-1:0]   shadow_cells [0:CELL_COUNT-1];
   int unsigned         shadow_cursor;
   logic [ATTR_W-1:0]   shadow_attribute;

   // Responses still owed by the block, oldest first.
   rsp_type             pending_responses [$];
   logic                pinned_active = 1'b0;
   rsp_type             pinned_response = '0;

   int                  error_count = 0;
   int                  responses_checked = 0;
   longint              cycle_count = 0;

   text_console_char_writer u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Fill the whole shadow screen with blanks in the current attribute.
   function automatic void blank_screen();
      for (int i = 0; i < CELL_COUNT; i++) begin
         shadow_cells[i] = {shadow_attribute, CHAR_SPACE};
      end
   endfunction

   // Linear offset of a saturated column and row.
   function automatic int unsigned saturated_offset(logic [COLUMN_IN_W-1:0] col,
                                                    logic [ROW_IN_W-1:0] row);
      int unsigned c;
      int unsigned r;
      c = (col > SCREEN_W - 1) ? SCREEN_W - 1 : col;
      r = (row > SCREEN_H - 1) ? SCREEN_H - 1 : row;
      return r * SCREEN_W + c;
   endfunction

   // Apply one request to the shadow console and return the response it owes.
   function automatic rsp_type console_response(req_type item);
      rsp_type     answer;
      int unsigned pos;
      int unsigned idx;
      answer = '0;
      case (op_type'(item.operation))
         OP_PRINT: begin
            pos = shadow_cursor;
            if (item.char_code == CHAR_NEWLINE) begin
               pos += SCREEN_W - (pos % SCREEN_W);
            end else if (item.char_code == CHAR_TAB) begin
               pos += TAB_W - (pos % TAB_W);
            end else begin
               shadow_cells[pos] = {shadow_attribute, item.char_code};
               pos++;
            end
            // Running off the end scrolls every row up and blanks the last one.
            if (pos >= CELL_COUNT) begin
               for (int i = 0; i < LAST_ROW_AT; i++) begin
                  shadow_cells[i] = shadow_cells[i + SCREEN_W];
               end
               for (int i = LAST_ROW_AT; i < CELL_COUNT; i++) begin
                  shadow_cells[i] = {shadow_attribute, CHAR_SPACE};
               end
               pos = LAST_ROW_AT;
            end
            shadow_cursor = pos;
         end
         OP_SET: begin
            shadow_cursor = saturated_offset(item.column, item.row);
         end
         OP_CLEAR: begin
            blank_screen();
         end
         OP_READ: begin
            idx = saturated_offset(item.column, item.row);
            answer.cell_char = shadow_cells[idx][CHAR_W-1:0];
            answer.cell_attr = shadow_cells[idx][CELL_W-1:CHAR_W];
         end
         default: ;
      endcase
      answer.cursor_offset = CURSOR_OFFSET_W'(shadow_cursor);
      answer.cursor_column = CURSOR_COLUMN_W'(shadow_cursor % SCREEN_W);
      answer.cursor_row    = CURSOR_ROW_W'(shadow_cursor / SCREEN_W);
      return answer;
   endfunction

   // Check accepted responses, then record accepted requests and attribute writes.
   always @(posedge clock) begin : transfer_monitor
      rsp_type wanted;
      if (reset) begin
         shadow_attribute = ATTR_RESET;
         shadow_cursor    = 0;
         blank_screen();
      end else begin
         if (rsp_valid && rsp_ready) begin
            responses_checked++;
            if (pending_responses.size() == 0) begin
               error_count++;
               if (error_count <= MAX_REPORTS) begin
                  $display("unexpected response at cycle %0d: %p", cycle_count, rsp_data);
               end
            end else begin
               wanted = pending_responses.pop_front();
               if (rsp_data.cursor_offset !== wanted.cursor_offset ||
                   rsp_data.cursor_column !== wanted.cursor_column ||
                   rsp_data.cursor_row    !== wanted.cursor_row    ||
                   rsp_data.cell_char     !== wanted.cell_char     ||
                   rsp_data.cell_attr     !== wanted.cell_attr) begin
                  error_count++;
                  if (error_count <= MAX_REPORTS) begin
                     $display("response %0d mismatch: offset %0d/%0d column %0d/%0d %s",
                              responses_checked, wanted.cursor_offset,
                              rsp_data.cursor_offset, wanted.cursor_column,
                              rsp_data.cursor_column, "(expected/actual)");
                     $display("   row %0d/%0d char %h/%h attr %h/%h",
                              wanted.cursor_row, rsp_data.cursor_row, wanted.cell_char,
                              rsp_data.cell_char, wanted.cell_attr, rsp_data.cell_attr);
                  end
               end
            end
         end
         if (csr_write_enable) begin
            shadow_attribute = csr_write_data;
         end
         if (req_valid && req_ready) begin
            wanted = console_response(req_data);
            pending_responses.push_back(pinned_active ? pinned_response : wanted);
         end
      end
   end

   // Receiver: changing stall patterns, plus two long hold-offs that back up the block.
   always @(negedge clock) begin : response_stalls
      static int holdoff_left  = 0;
      static int holdoffs_done = 0;
      static int pattern_left  = 0;
      static int stall_pattern = 0;
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if ((holdoffs_done == 0 && responses_checked >= 150) ||
                   (holdoffs_done == 1 && responses_checked >= 550)) begin
         holdoffs_done++;
         holdoff_left = HOLDOFF_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = $urandom_range(0, 2);
            pattern_left  = $urandom_range(16, 128);
         end
         pattern_left--;
         case (stall_pattern)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles with %0d responses pending",
                  cycle_count, pending_responses.size());
         $display("FAIL");
         $finish;
      end
   end

   // Offer one request and hold it until the block takes it.
   task automatic offer_request(req_type item, logic pinned, rsp_type result);
      @(negedge clock);
      req_valid       <= 1'b1;
      req_data        <= item;
      pinned_active   = pinned;
      pinned_response = result;
      do @(posedge clock); while (!req_ready);
   endtask

   // Keep the request channel quiet for a number of cycles.
   task automatic hold_requests(int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   // Stop sending and wait until every owed response has arrived.
   task automatic wait_for_responses();
      hold_requests(1);
      while (pending_responses.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_attribute(logic [ATTR_W-1:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Coordinate mostly on the screen, sometimes past its edge.
   function automatic logic [COLUMN_IN_W-1:0] random_column();
      return ($urandom_range(0, 9) == 0) ? COLUMN_IN_W'($urandom_range(0, 127))
                                         : COLUMN_IN_W'($urandom_range(0, SCREEN_W - 1));
   endfunction

   function automatic logic [ROW_IN_W-1:0] random_row();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return ROW_IN_W'(SCREEN_H - 1);
      if (pick == 3) return ROW_IN_W'($urandom_range(0, 31));
      return ROW_IN_W'($urandom_range(0, SCREEN_H - 1));
   endfunction

   // Mostly printing, with cursor moves biased toward the bottom row so that
   // scrolls come often, and rare clears since each one walks the whole store.
   function automatic req_type random_request();
      req_type     item;
      int unsigned pick;
      item.char_code = CHAR_W'($urandom);
      item.column    = COLUMN_IN_W'($urandom);
      item.row       = ROW_IN_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
         item.operation = OP_PRINT;
         pick = $urandom_range(0, 19);
         if (pick < 2) item.char_code = CHAR_NEWLINE;
         else if (pick < 4) item.char_code = CHAR_TAB;
      end else if (pick < 78) begin
         item.operation = OP_SET;
         item.column    = random_column();
         item.row       = random_row();
      end else if (pick < 80) begin
         item.operation = OP_CLEAR;
      end else begin
         item.operation = OP_READ;
         item.column    = random_column();
         item.row       = random_row();
      end
      return item;
   endfunction

   initial begin
      logic [ATTR_W-1:0] phase_attribute;
      int sent;
      int burst;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table, starting from the reset attribute.
      foreach (DIRECTED_ROWS[i]) begin
         offer_request(DIRECTED_ROWS[i].item, DIRECTED_ROWS[i].pinned,
                       DIRECTED_ROWS[i].result);
         if ($urandom_range(0, 3) == 0) hold_requests($urandom_range(1, 6));
      end
      wait_for_responses();
      pinned_active = 1'b0;

      // Random phases, each under its own attribute, extremes first.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0:       phase_attribute = 8'hFF;
            1:       phase_attribute = 8'h00;
            default: phase_attribute = ATTR_W'($urandom);
         endcase
         write_attribute(phase_attribute);
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            burst = $urandom_range(1, 24);
            for (int k = 0; k < burst && sent < ITEMS_PER_PHASE; k++) begin
               offer_request(random_request(), 1'b0, '0);
               sent++;
            end
            if ($urandom_range(0, 3) != 0) hold_requests($urandom_range(1, 12));
         end
         wait_for_responses();
      end

      if (error_count == 0 && pending_responses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
